// ----- sv/rpsg_pkg.sv -----
package rpsg_pkg;

   // Pixel coordinate and center fraction widths.
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;

   // Field widths fixed by the stream format.
   localparam int CORNER_W = 13;
   localparam int CENTER_W = 22;
   localparam int WT_W     = 16;
   localparam int LIMIT_W  = 59;

   // Corner saturation point, one past the last pixel.
   localparam logic [CORNER_W-1:0] CORNER_TOP = CORNER_W'(1 << COORD_BITS);

   // Signed distance (x + 0.5 - c) in Q.FRAC_BITS and its magnitude.
   localparam int POS_W = COORD_BITS + FRAC_BITS;
   localparam int D_W   = ((POS_W > CENTER_W - 1) ? POS_W : CENTER_W - 1) + 2;
   localparam int MAG_W = D_W - 1;

   // Shared multiplier and weighted-sum accumulator.
   localparam int PROD_W = 2 * MAG_W;
   localparam int ACC_W  = 2 * MAG_W + WT_W + 1;

   // Stream word layouts.
   localparam int REQ_DATA_BITS = 1 + 4 * CORNER_W + 2 * CENTER_W + 2 * WT_W + LIMIT_W;
   localparam int REQ_DATA_W    = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8;

   // Request kinds carried in req_tuser.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_NEXT  = 1'b1;

   // Region modes.
   localparam logic MODE_BOX     = 1'b0;
   localparam logic MODE_QUADRIC = 1'b1;

   // Saturate a raw corner to one past the last pixel.
   function automatic logic [CORNER_W-1:0] clamp_corner(input logic [CORNER_W-1:0] v);
      return (v > CORNER_TOP) ? CORNER_TOP : v;
   endfunction

endpackage

// ----- sv/region_pixel_scan_generator.sv -----
// Region pixel scan generator.
//
// Each request beat on req_ (tuser = kind) yields exactly one response beat on
// rsp_. A start beat latches a box, a mode and the quadric operands, and answers
// with the first selected pixel; a next beat answers with the following pixel
// in raster order (x fastest, upper corners exclusive). When no pixel remains
// the response carries pixel 0,0 with the done flag in rsp_tuser.
//
// Sequence: an accepted request moves the sequencer from idle to a raster step
// (next beats only), then for a quadric region through a candidate test (a
// distance step, seven shared multiply/accumulate phases, one compare) and back
// to the step until a pixel is selected or the scan runs off the end, and then
// to the output state, which loads the response register. A start beat skips
// the step for its first candidate. The single 22x22 multiplier is used three
// times per axis. One request is in work at a time; req_tready is high only
// while the sequencer is idle.
//
// The response sits in an output register: a new request is accepted while a
// finished response waits, and a stalled rsp_tready holds the sequencer in its
// output state once the next result is ready. Synchronous reset clears the
// sequencer and the output valid and leaves the block finished (no region).
module region_pixel_scan_generator
   import rpsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] shape_mode, [13:1] x_lo, [26:14] y_lo, [39:27] x_hi, [52:40] y_hi,
   // [74:53] center_x, [96:75] center_y, [112:97] weight_x,
   // [128:113] weight_y, [187:129] limit, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                  req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] pixel_x, [23:12] pixel_y
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] done_res
   output logic                  rsp_tuser
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STEP = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   // Multiply/accumulate phases within ST_MUL.
   localparam logic [2:0] PH_SQ_X  = 3'd0;
   localparam logic [2:0] PH_LO_X  = 3'd1;
   localparam logic [2:0] PH_HI_X  = 3'd2;
   localparam logic [2:0] PH_SQ_Y  = 3'd3;
   localparam logic [2:0] PH_LO_Y  = 3'd4;
   localparam logic [2:0] PH_HI_Y  = 3'd5;
   localparam logic [2:0] PH_LAST  = 3'd6;

   localparam int OFS_XLO = 1;
   localparam int OFS_YLO = OFS_XLO + CORNER_W;
   localparam int OFS_XHI = OFS_YLO + CORNER_W;
   localparam int OFS_YHI = OFS_XHI + CORNER_W;
   localparam int OFS_CX  = OFS_YHI + CORNER_W;
   localparam int OFS_CY  = OFS_CX + CENTER_W;
   localparam int OFS_WX  = OFS_CY + CENTER_W;
   localparam int OFS_WY  = OFS_WX + WT_W;
   localparam int OFS_LIM = OFS_WY + WT_W;

   // Half a pixel in Q.FRAC_BITS.
   localparam logic [D_W-1:0] HALF_PIX = D_W'(1 << (FRAC_BITS - 1));

   logic [2:0]            state_ff, state_in;
   logic [2:0]            phase_ff, phase_in;

   logic [COORD_BITS-1:0] scan_x_ff, scan_x_in;
   logic [COORD_BITS-1:0] scan_y_ff, scan_y_in;
   logic                  finished_ff, finished_in;
   logic                  mode_ff, mode_in;
   logic [COORD_BITS-1:0] box_lo_x_ff, box_lo_x_in;
   logic [COORD_BITS-1:0] box_lo_y_ff, box_lo_y_in;
   logic [CORNER_W-1:0]   box_hi_x_ff, box_hi_x_in;
   logic [CORNER_W-1:0]   box_hi_y_ff, box_hi_y_in;
   logic [CENTER_W-1:0]   ctr_x_ff, ctr_x_in;
   logic [CENTER_W-1:0]   ctr_y_ff, ctr_y_in;
   logic [WT_W-1:0]       wt_x_ff, wt_x_in;
   logic [WT_W-1:0]       wt_y_ff, wt_y_in;
   logic [LIMIT_W-1:0]    thresh_ff, thresh_in;

   logic [MAG_W-1:0]      mag_x_ff, mag_x_in;
   logic [MAG_W-1:0]      mag_y_ff, mag_y_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [MAG_W-1:0]      hi_ff, hi_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                  rsp_done_ff, rsp_done_in;

   // Request fields.
   logic                  f_mode;
   logic [CORNER_W-1:0]   f_ax, f_ay, f_bx, f_by;
   logic                  req_fire;
   logic                  out_free;

   // Shared multiplier.
   logic [MAG_W-1:0]      mul_a, mul_b;

   // Raster step and distance helpers.
   logic [CORNER_W-1:0]   next_x, next_y;
   logic signed [D_W-1:0] d_x, d_y;

   assign f_mode = req_tdata[0];
   assign f_ax   = clamp_corner(req_tdata[OFS_XLO +: CORNER_W]);
   assign f_ay   = clamp_corner(req_tdata[OFS_YLO +: CORNER_W]);
   assign f_bx   = clamp_corner(req_tdata[OFS_XHI +: CORNER_W]);
   assign f_by   = clamp_corner(req_tdata[OFS_YHI +: CORNER_W]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign next_x = CORNER_W'(scan_x_ff) + CORNER_W'(1);
   assign next_y = CORNER_W'(scan_y_ff) + CORNER_W'(1);

   // Distance from pixel center to region center, Q.FRAC_BITS.
   assign d_x = signed'(D_W'({scan_x_ff, {FRAC_BITS{1'b0}}}) + HALF_PIX)
              - D_W'(signed'(ctr_x_ff));
   assign d_y = signed'(D_W'({scan_y_ff, {FRAC_BITS{1'b0}}}) + HALF_PIX)
              - D_W'(signed'(ctr_y_ff));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (phase_ff)
         PH_SQ_X: begin
            mul_a = mag_x_ff;
            mul_b = mag_x_ff;
         end
         PH_LO_X: begin
            mul_a = prod_ff[MAG_W-1:0];
            mul_b = MAG_W'(wt_x_ff);
         end
         PH_HI_X: begin
            mul_a = hi_ff;
            mul_b = MAG_W'(wt_x_ff);
         end
         PH_SQ_Y: begin
            mul_a = mag_y_ff;
            mul_b = mag_y_ff;
         end
         PH_LO_Y: begin
            mul_a = prod_ff[MAG_W-1:0];
            mul_b = MAG_W'(wt_y_ff);
         end
         PH_HI_Y: begin
            mul_a = hi_ff;
            mul_b = MAG_W'(wt_y_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      scan_x_in   = scan_x_ff;
      scan_y_in   = scan_y_ff;
      finished_in = finished_ff;
      mode_in     = mode_ff;
      box_lo_x_in = box_lo_x_ff;
      box_lo_y_in = box_lo_y_ff;
      box_hi_x_in = box_hi_x_ff;
      box_hi_y_in = box_hi_y_ff;
      ctr_x_in    = ctr_x_ff;
      ctr_y_in    = ctr_y_ff;
      wt_x_in     = wt_x_ff;
      wt_y_in     = wt_y_ff;
      thresh_in   = thresh_ff;
      mag_x_in    = mag_x_ff;
      mag_y_in    = mag_y_ff;
      prod_in     = prod_ff;
      hi_in       = hi_ff;
      acc_in      = acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_done_in  = rsp_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == REQ_START) begin
                  // Latch operands, sort corners per axis, park at the low corner.
                  mode_in     = f_mode;
                  ctr_x_in    = req_tdata[OFS_CX +: CENTER_W];
                  ctr_y_in    = req_tdata[OFS_CY +: CENTER_W];
                  wt_x_in     = req_tdata[OFS_WX +: WT_W];
                  wt_y_in     = req_tdata[OFS_WY +: WT_W];
                  thresh_in   = req_tdata[OFS_LIM +: LIMIT_W];
                  box_lo_x_in = COORD_BITS'((f_ax < f_bx) ? f_ax : f_bx);
                  box_hi_x_in = (f_ax < f_bx) ? f_bx : f_ax;
                  box_lo_y_in = COORD_BITS'((f_ay < f_by) ? f_ay : f_by);
                  box_hi_y_in = (f_ay < f_by) ? f_by : f_ay;
                  scan_x_in   = COORD_BITS'((f_ax < f_bx) ? f_ax : f_bx);
                  scan_y_in   = COORD_BITS'((f_ay < f_by) ? f_ay : f_by);
                  if (f_ax == f_bx || f_ay == f_by) begin
                     finished_in = 1'b1;
                     state_in    = ST_OUT;
                  end else begin
                     finished_in = 1'b0;
                     state_in    = (f_mode == MODE_QUADRIC) ? ST_DIFF : ST_OUT;
                  end
               end else begin
                  state_in = finished_ff ? ST_OUT : ST_STEP;
               end
            end
         end

         ST_STEP: begin
            // Advance one pixel in raster order; wrap to done past the last row.
            if (next_x < box_hi_x_ff) begin
               scan_x_in = next_x[COORD_BITS-1:0];
               state_in  = (mode_ff == MODE_QUADRIC) ? ST_DIFF : ST_OUT;
            end else begin
               scan_x_in = box_lo_x_ff;
               if (next_y < box_hi_y_ff) begin
                  scan_y_in = next_y[COORD_BITS-1:0];
                  state_in  = (mode_ff == MODE_QUADRIC) ? ST_DIFF : ST_OUT;
               end else begin
                  scan_y_in   = box_lo_y_ff;
                  finished_in = 1'b1;
                  state_in    = ST_OUT;
               end
            end
         end

         ST_DIFF: begin
            mag_x_in = MAG_W'(d_x[D_W-1] ? -d_x : d_x);
            mag_y_in = MAG_W'(d_y[D_W-1] ? -d_y : d_y);
            acc_in   = '0;
            phase_in = PH_SQ_X;
            state_in = ST_MUL;
         end

         ST_MUL: begin
            // Square each magnitude, then weight it in two halves.
            prod_in = mul_a * mul_b;
            case (phase_ff)
               PH_LO_X, PH_LO_Y: begin
                  hi_in = prod_ff[PROD_W-1:MAG_W];
               end
               PH_HI_X, PH_HI_Y: begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
               end
               PH_SQ_Y, PH_LAST: begin
                  acc_in = acc_ff + (ACC_W'(prod_ff) << MAG_W);
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
            if (phase_ff == PH_LAST) begin
               phase_in = PH_SQ_X;
               state_in = ST_CMP;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end

         ST_CMP: begin
            state_in = (acc_ff <= ACC_W'(thresh_ff)) ? ST_OUT : ST_STEP;
         end

         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = finished_ff;
               rsp_x_in     = finished_ff ? '0 : scan_x_ff;
               rsp_y_in     = finished_ff ? '0 : scan_y_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SQ_X;
         finished_ff  <= 1'b1;
         mode_ff      <= MODE_BOX;
         scan_x_ff    <= '0;
         scan_y_ff    <= '0;
         box_lo_x_ff  <= '0;
         box_lo_y_ff  <= '0;
         box_hi_x_ff  <= '0;
         box_hi_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         finished_ff  <= finished_in;
         mode_ff      <= mode_in;
         scan_x_ff    <= scan_x_in;
         scan_y_ff    <= scan_y_in;
         box_lo_x_ff  <= box_lo_x_in;
         box_lo_y_ff  <= box_lo_y_in;
         box_hi_x_ff  <= box_hi_x_in;
         box_hi_y_ff  <= box_hi_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_x_ff    <= ctr_x_in;
      ctr_y_ff    <= ctr_y_in;
      wt_x_ff     <= wt_x_in;
      wt_y_ff     <= wt_y_in;
      thresh_ff   <= thresh_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_done_ff;

   // A done response always carries pixel 0,0.
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("done response with nonzero pixel");

   // An accepted request always leaves idle.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after a request");

   // While a region is open the scan position stays inside the box.
   a_scan_in_box: assert property (@(posedge clock) disable iff (reset)
      (!finished_ff && state_ff == ST_IDLE) |->
         (CORNER_W'(scan_x_ff) < box_hi_x_ff && scan_x_ff >= box_lo_x_ff &&
          CORNER_W'(scan_y_ff) < box_hi_y_ff && scan_y_ff >= box_lo_y_ff))
      else $error("scan position outside the open box");

   // The phase counter only runs inside the multiply state.
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MUL) |-> (phase_ff == PH_SQ_X))
      else $error("phase counter moved outside multiply state");

   // A box-mode region never enters the quadric datapath.
   a_box_no_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && mode_ff == MODE_BOX) |=> (state_ff != ST_DIFF))
      else $error("box mode entered distance computation");

endmodule

// ----- dv/region_pixel_scan_generator_tb.sv -----
`timescale 1ns / 100ps

// Stream testbench for the region pixel scan generator.
//
// Every request beat is mirrored into a local scan predictor that keeps its
// own copy of the region (sorted box, scan position, quadric operands) and
// works out the one response that the beat must produce. Expected responses
// wait in a queue; a monitor on the response side pops one per accepted beat
// and compares pixel x, pixel y and the done flag.
//
// Stimulus runs as a handful of named tests: a next beat with no region, box
// walks with sorted and saturated corners, empty boxes, quadric corner cases,
// then random regions that are mostly well-formed start-then-walk sequences
// with random content. Both sides idle at random, with whole regions run
// back to back as well.
module region_pixel_scan_generator_tb;
   import rpsg_pkg::*;

   // One request beat before packing: kind goes on tuser, the rest on tdata.
   typedef struct {
      logic                kind;
      logic                mode;
      logic [CORNER_W-1:0] x_lo;
      logic [CORNER_W-1:0] y_lo;
      logic [CORNER_W-1:0] x_hi;
      logic [CORNER_W-1:0] y_hi;
      logic [CENTER_W-1:0] ctr_x;
      logic [CENTER_W-1:0] ctr_y;
      logic [WT_W-1:0]     wt_x;
      logic [WT_W-1:0]     wt_y;
      logic [LIMIT_W-1:0]  lim;
   } scan_req_type;

   // One response beat, laid out as {rsp_tuser, rsp_tdata}.
   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Responses still owed by the block, oldest first.
   pixel_type expected_pixels[$];
   int        bad_beats = 0;
   int        items_sent = 0;

   // Idle budgets per beat; zero runs a side back to back.
   int     req_gap_max = 4;
   int     rsp_gap_max = 4;
   int     rsp_hold = 0;

   // Scan predictor state, reset to "finished, no region".
   logic [CORNER_W-1:0]        pos_x = '0;
   logic [CORNER_W-1:0]        pos_y = '0;
   logic [CORNER_W-1:0]        lo_x = '0;
   logic [CORNER_W-1:0]        lo_y = '0;
   logic [CORNER_W-1:0]        hi_x = '0;
   logic [CORNER_W-1:0]        hi_y = '0;
   logic                       scan_done = 1'b1;
   logic                       quad_mode = MODE_BOX;
   logic signed [CENTER_W-1:0] ctr_x_q = '0;
   logic signed [CENTER_W-1:0] ctr_y_q = '0;
   logic [WT_W-1:0]            wt_x_q = '0;
   logic [WT_W-1:0]            wt_y_q = '0;
   logic [LIMIT_W-1:0]         thresh_q = '0;

   region_pixel_scan_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #50_000_000;
      $display("region_pixel_scan_generator verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Scan predictor
   // ------------------------------------------------------------------

   // Weighted squared distance of one axis, exact: w * (pos + 0.5 - ctr)^2
   // with pos in pixels and ctr in Q.FRAC_BITS. 128 bits never overflow, and
   // the block's accumulator holds any sum without wrapping.
   function automatic logic [127:0] axis_cost(input logic [CORNER_W-1:0] pos,
                                              input logic signed [CENTER_W-1:0] ctr,
                                              input logic [WT_W-1:0] wt);
      longint       offset;
      logic [127:0] mag;
      offset = (longint'(pos) <<< FRAC_BITS) + (longint'(1) <<< (FRAC_BITS - 1))
               - longint'(ctr);
      mag = (offset < 0) ? 128'(-offset) : 128'(offset);
      return mag * mag * 128'(wt);
   endfunction

   function automatic logic pixel_selected();
      return (axis_cost(pos_x, ctr_x_q, wt_x_q) + axis_cost(pos_y, ctr_y_q, wt_y_q))
             <= 128'(thresh_q);
   endfunction

   // Step one pixel in raster order; false once past the last row.
   function automatic logic advance_pos();
      pos_x = pos_x + 1'b1;
      if (pos_x < hi_x) begin
         return 1'b1;
      end
      pos_x = lo_x;
      pos_y = pos_y + 1'b1;
      if (pos_y < hi_y) begin
         return 1'b1;
      end
      pos_y = lo_y;
      return 1'b0;
   endfunction

   // Move to the next selected pixel, or mark the region finished.
   function automatic void seek_next();
      do begin
         if (!advance_pos()) begin
            scan_done = 1'b1;
            return;
         end
      end while (quad_mode == MODE_QUADRIC && !pixel_selected());
   endfunction

   function automatic pixel_type predict_scan(input scan_req_type r);
      logic [CORNER_W-1:0] ax;
      logic [CORNER_W-1:0] ay;
      logic [CORNER_W-1:0] bx;
      logic [CORNER_W-1:0] by;
      pixel_type           res;
      if (r.kind == REQ_START) begin
         // Saturate corners past the edge, then sort each axis.
         ax = (r.x_lo > CORNER_TOP) ? CORNER_TOP : r.x_lo;
         ay = (r.y_lo > CORNER_TOP) ? CORNER_TOP : r.y_lo;
         bx = (r.x_hi > CORNER_TOP) ? CORNER_TOP : r.x_hi;
         by = (r.y_hi > CORNER_TOP) ? CORNER_TOP : r.y_hi;
         quad_mode = r.mode;
         ctr_x_q   = r.ctr_x;
         ctr_y_q   = r.ctr_y;
         wt_x_q    = r.wt_x;
         wt_y_q    = r.wt_y;
         thresh_q  = r.lim;
         lo_x = (ax < bx) ? ax : bx;
         hi_x = (ax < bx) ? bx : ax;
         lo_y = (ay < by) ? ay : by;
         hi_y = (ay < by) ? by : ay;
         pos_x = lo_x;
         pos_y = lo_y;
         // A flat box on either axis has no pixel at all.
         scan_done = (ax == bx) || (ay == by);
         if (!scan_done && quad_mode == MODE_QUADRIC && !pixel_selected()) begin
            seek_next();
         end
      end else if (!scan_done) begin
         seek_next();
      end
      // Once finished, next beats leave the state alone and answer done.
      res.done = scan_done;
      res.x    = scan_done ? '0 : pos_x[COORD_BITS-1:0];
      res.y    = scan_done ? '0 : pos_y[COORD_BITS-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Next beat; every field but the kind is ignored, so fill it with noise.
   function automatic scan_req_type next_beat();
      scan_req_type r;
      r.kind  = REQ_NEXT;
      r.mode  = 1'($urandom);
      r.x_lo  = CORNER_W'($urandom);
      r.y_lo  = CORNER_W'($urandom);
      r.x_hi  = CORNER_W'($urandom);
      r.y_hi  = CORNER_W'($urandom);
      r.ctr_x = CENTER_W'($urandom);
      r.ctr_y = CENTER_W'($urandom);
      r.wt_x  = WT_W'($urandom);
      r.wt_y  = WT_W'($urandom);
      r.lim   = LIMIT_W'({$urandom, $urandom});
      return r;
   endfunction

   function automatic scan_req_type start_beat(input logic mode, input int xa, input int ya,
                                               input int xb, input int yb);
      scan_req_type r;
      r = next_beat();
      r.kind = REQ_START;
      r.mode = mode;
      r.x_lo = CORNER_W'(xa);
      r.y_lo = CORNER_W'(ya);
      r.x_hi = CORNER_W'(xb);
      r.y_hi = CORNER_W'(yb);
      return r;
   endfunction

   // Present one beat after a random gap and hold it until accepted. Valid
   // stays high on return so a gapless follower just swaps the data.
   task automatic send_scan(input scan_req_type r);
      int        gap;
      pixel_type owed;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.kind;
      req_tdata  = REQ_DATA_W'({r.lim, r.wt_y, r.wt_x, r.ctr_y, r.ctr_x,
                                r.y_hi, r.x_hi, r.y_lo, r.x_lo, r.mode});
      do @(posedge clock); while (!req_tready);
      owed = predict_scan(r);
      expected_pixels = {expected_pixels, owed};
      items_sent++;
   endtask

   // Drop valid and hold off until every owed response is back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Stall the response channel for the drawn number of cycles after a beat.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready = 1'b0;
         rsp_hold   = rsp_hold - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[2*COORD_BITS-1:0]};
         if (expected_pixels.size() == 0) begin
            if (bad_beats < 10) begin
               $display("%0t: response beat with nothing owed: x=%0d y=%0d done=%0b",
                        $time, got.x, got.y, got.done);
            end
            bad_beats++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.done !== want.done) begin
               if (bad_beats < 10) begin
                  $display("%0t: pixel mismatch: expected x=%0d y=%0d done=%0b, got x=%0d y=%0d done=%0b",
                           $time, want.x, want.y, want.done, got.x, got.y, got.done);
               end
               bad_beats++;
            end
         end
         rsp_hold = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset there is no region, so a next beat must answer done.
   task automatic test_next_without_region();
      send_scan(next_beat());
   endtask

   task automatic test_box_scan();
      // Corners given high-first: sorting yields a 3x2 box at the origin.
      // Walk all six pixels, the done answer, and one more next after done.
      send_scan(start_beat(MODE_BOX, 3, 2, 0, 0));
      repeat (7) send_scan(next_beat());
      // Far corner: raw 8191 saturates to the edge, leaving two pixels.
      send_scan(start_beat(MODE_BOX, 8191, 4095, 4094, 8191));
      repeat (2) send_scan(next_beat());
      // Whole plane, swapped per axis; only the first two pixels.
      send_scan(start_beat(MODE_BOX, 0, 8191, 8191, 0));
      send_scan(next_beat());
   endtask

   task automatic test_empty_boxes();
      send_scan(start_beat(MODE_BOX, 5, 0, 5, 9));
      send_scan(start_beat(MODE_QUADRIC, 0, 7, 9, 7));
      // Both x corners saturate to the same edge value.
      send_scan(start_beat(MODE_BOX, 4097, 0, 8191, 3));
   endtask

   task automatic test_quadric_cases();
      scan_req_type r;
      // Zero threshold with the center on a pixel center: one pixel only.
      r = start_beat(MODE_QUADRIC, 0, 0, 8, 8);
      r.ctr_x = CENTER_W'((3 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
      r.ctr_y = CENTER_W'((4 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
      r.wt_x  = '1;
      r.wt_y  = '1;
      r.lim   = '0;
      send_scan(r);
      send_scan(next_beat());
      // Centers at both signed extremes, far off: nothing selected.
      r = start_beat(MODE_QUADRIC, 10, 10, 14, 14);
      r.ctr_x = {1'b1, {(CENTER_W-1){1'b0}}};
      r.ctr_y = {1'b0, {(CENTER_W-1){1'b1}}};
      r.wt_x  = '1;
      r.wt_y  = '1;
      r.lim   = '0;
      send_scan(r);
      // Widest threshold over the whole plane: every pixel is in.
      r = start_beat(MODE_QUADRIC, 0, 0, 8191, 8191);
      r.ctr_x = '0;
      r.ctr_y = '0;
      r.wt_x  = '1;
      r.wt_y  = '1;
      r.lim   = '1;
      send_scan(r);
      send_scan(next_beat());
      // Zero weights make any threshold pass.
      r = start_beat(MODE_QUADRIC, 4, 3, 2, 2);
      r.wt_x = '0;
      r.wt_y = '0;
      r.lim  = '0;
      send_scan(r);
      repeat (2) send_scan(next_beat());
   endtask

   // One random region: a start, then a partial walk or a full walk that runs
   // a little past done. Quadric boxes stay small since every candidate runs
   // the block's whole test sequence; box mode may span the plane.
   task automatic random_region();
      scan_req_type r;
      int           w;
      int           h;
      int           base_x;
      int           base_y;
      int           steps;
      int           tail;
      r = next_beat();
      r.kind = REQ_START;
      if ($urandom_range(0, 15) == 0) begin
         // Raw noise start; clip only the quadric box size.
         w = 8;
         h = 8;
         if (r.mode == MODE_QUADRIC) begin
            r.x_lo = CORNER_W'($urandom_range(0, 8183));
            r.y_lo = CORNER_W'($urandom_range(0, 8183));
            r.x_hi = r.x_lo + CORNER_W'($urandom_range(0, 8));
            r.y_hi = r.y_lo + CORNER_W'($urandom_range(0, 8));
         end
      end else begin
         w = $urandom_range(0, 12);
         h = $urandom_range(0, 12);
         if (r.mode == MODE_BOX && $urandom_range(0, 3) == 0) begin
            w = $urandom_range(0, 4096);
            h = $urandom_range(0, 4096);
         end
         base_x = $urandom_range(0, 4100);
         base_y = $urandom_range(0, 4100);
         r.x_lo = CORNER_W'(base_x);
         r.x_hi = CORNER_W'(base_x + w);
         r.y_lo = CORNER_W'(base_y);
         r.y_hi = CORNER_W'(base_y + h);
         if ($urandom_range(0, 1) == 1) begin
            r.x_lo = CORNER_W'(base_x + w);
            r.x_hi = CORNER_W'(base_x);
         end
         if ($urandom_range(0, 1) == 1) begin
            r.y_lo = CORNER_W'(base_y + h);
            r.y_hi = CORNER_W'(base_y);
         end
         // Mostly put the center inside the box so the shape cuts through it.
         if ($urandom_range(0, 3) != 0) begin
            r.ctr_x = CENTER_W'((base_x << FRAC_BITS)
                                + $urandom_range(0, (w << FRAC_BITS) + 255));
            r.ctr_y = CENTER_W'((base_y << FRAC_BITS)
                                + $urandom_range(0, (h << FRAC_BITS) + 255));
         end
         // Spread the threshold over many octaves, from all-in to almost none.
         r.lim = LIMIT_W'({$urandom, $urandom} >> $urandom_range(0, 45));
      end
      send_scan(r);
      steps = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 12);
      tail  = $urandom_range(0, 2);
      for (int i = 0; i < steps; i++) begin
         if (scan_done) begin
            if (tail == 0) begin
               break;
            end
            tail--;
         end
         send_scan(next_beat());
      end
   endtask

   task automatic test_random_regions();
      int regions;
      regions   = 0;
      items_sent = 0;
      while (items_sent < 1800) begin
         // Now and then let the block run dry before the next region.
         if (regions % 40 == 39) begin
            wait_drained();
         end
         req_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 4;
         rsp_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 4;
         random_region();
         regions++;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_next_without_region();
      test_box_scan();
      test_empty_boxes();
      test_quadric_cases();
      wait_drained();
      test_random_regions();
      wait_drained();
      // Leave room for any stray beat after the last owed one.
      repeat (20) @(posedge clock);
      if (bad_beats == 0 && expected_pixels.size() == 0) begin
         $display("region_pixel_scan_generator verification clean");
      end else begin
         $display("region_pixel_scan_generator verification failed");
      end
      $finish;
   end

endmodule
